// ----- hdl/ebc_pkg.sv -----
// ============================================================================
// ebc_pkg: shared constants and functions for the ellipse box/covariance block
// Holds the CORDIC angle table, the gain seed and the fixed output limits.
// ============================================================================
package ebc_pkg;

    localparam int CORDIC_STAGES_DEF = 16;
    localparam int AXIS_BITS_DEF     = 16;
    localparam int ANGLE_BITS_DEF    = 16;

    // CORDIC datapath: Q2.30 in a signed 34-bit word, angle in a 33-bit word
    localparam int CW = 34;
    localparam int ZW = 33;
    localparam logic signed [CW-1:0] GAIN_Q30 = 34'sd652032874;

    localparam int CENTER_W = 20;
    localparam int SIZE_W   = 17;
    localparam int COV_W    = 32;
    localparam int SQRT_IN_W = 34;      // 4*cov fits in 34 bits
    localparam int SQRT_STEPS = 17;     // one result bit per cell

    function automatic logic signed [ZW-1:0] atan_turn(input int i);
        logic [31:0] v;
        case (i)
            0:  v = 32'h20000000;  1:  v = 32'h12E4051E;  2:  v = 32'h09FB385B;
            3:  v = 32'h051111D4;  4:  v = 32'h028B0D43;  5:  v = 32'h0145D7E1;
            6:  v = 32'h00A2F61E;  7:  v = 32'h00517C55;  8:  v = 32'h0028BE53;
            9:  v = 32'h00145F2F;  10: v = 32'h000A2F98;  11: v = 32'h000517CC;
            12: v = 32'h00028BE6;  13: v = 32'h000145F3;  14: v = 32'h0000A2FA;
            15: v = 32'h0000517D;  16: v = 32'h000028BE;  17: v = 32'h0000145F;
            18: v = 32'h00000A30;  19: v = 32'h00000518;  20: v = 32'h0000028C;
            21: v = 32'h00000146;  22: v = 32'h000000A3;  23: v = 32'h00000051;
            default: v = 32'h0;
        endcase
        return $signed({1'b0, v});
    endfunction

endpackage

// ----- hdl/ellipse_box_and_covariance.sv -----
// ============================================================================
// ellipse_box_and_covariance: rotated ellipse to covariance and bounding box
// CORDIC chain for sine/cosine, multiplier stages, square-root chains for box.
// ============================================================================
// Stages from input beat to output register: input fold register, CORDIC cells,
// 4 math stages, 17 square-root cells.
// Throughput: one beat per cycle; every stage advances together whenever the
// output register is empty or being drained, so a full pipe stalls as a unit.
// Reset: rst_n clears the per-stage valid bits only; payload is not reset.
module ellipse_box_and_covariance
    import ebc_pkg::*;
#(
    parameter int CORDIC_STAGES = CORDIC_STAGES_DEF,
    parameter int AXIS_BITS     = AXIS_BITS_DEF,
    parameter int ANGLE_BITS    = ANGLE_BITS_DEF
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // semi_axis_a[A-1:0], semi_axis_b, rotation, center_x[19:0], center_y[19:0]
    input  logic [((2*AXIS_BITS+ANGLE_BITS+40+7)/8)*8-1:0] s_axis_tdata,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // box_x[19:0], box_y, box_width[16:0], box_height, cov_xx[31:0], cov_xy, cov_yy
    output logic [175:0] m_axis_tdata
);
    localparam int A  = AXIS_BITS;
    localparam int A2 = 2 * AXIS_BITS;
    localparam int NS = (CORDIC_STAGES < 24) ? CORDIC_STAGES : 24;
    // math stages after CORDIC: sign fix(1) c2/s2/cs(1) products(1) sums/sat(1)
    localparam int MS = 4;
    localparam int LAT = 1 + NS + MS + SQRT_STEPS;

    // pipeline advance: whole chain moves when output can accept
    logic adv;
    logic [LAT-1:0] vld_reg;
    assign adv = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[LAT-2:0], s_axis_tvalid};
    end
    assign m_axis_tvalid = vld_reg[LAT-1];

    // ---------------- input unpack and angle fold ----------------
    logic [A-1:0] in_a, in_b;
    logic [ANGLE_BITS-1:0] in_rot;
    logic [CENTER_W-1:0] in_cx, in_cy;
    assign in_a   = s_axis_tdata[A-1:0];
    assign in_b   = s_axis_tdata[A2-1:A];
    assign in_rot = s_axis_tdata[A2+ANGLE_BITS-1:A2];
    assign in_cx  = s_axis_tdata[A2+ANGLE_BITS+CENTER_W-1:A2+ANGLE_BITS];
    assign in_cy  = s_axis_tdata[A2+ANGLE_BITS+2*CENTER_W-1:A2+ANGLE_BITS+CENTER_W];

    logic signed [ZW-1:0] z0, z0_next;
    logic flip_next;
    always_comb
    begin
        z0 = ZW'($signed({in_rot, {(32-ANGLE_BITS){1'b0}}}));
        flip_next = 1'b0;
        z0_next = z0;
        if (z0 > (ZW'(1) <<< 30))
        begin
            z0_next = z0 - (ZW'(1) <<< 31);
            flip_next = 1'b1;
        end
        else if (z0 < -(ZW'(1) <<< 30))
        begin
            z0_next = z0 + (ZW'(1) <<< 31);
            flip_next = 1'b1;
        end
    end

    // side data carried along the CORDIC chain
    typedef struct packed {
        logic [A-1:0] a;
        logic [A-1:0] b;
        logic flip;
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
    } side_t;

    side_t side_reg [0:NS];
    logic signed [ZW-1:0] z_in0_reg;
    logic signed [CW-1:0] cx_w [0:NS];
    logic signed [CW-1:0] cy_w [0:NS];
    logic signed [ZW-1:0] cz_w [0:NS];

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            side_reg[0] <= '{a: in_a, b: in_b, flip: flip_next, cx: in_cx, cy: in_cy};
            z_in0_reg <= z0_next;
        end
    end
    assign cx_w[0] = GAIN_Q30;
    assign cy_w[0] = '0;
    assign cz_w[0] = z_in0_reg;

    for (genvar g = 0; g < NS; g++)
    begin : g_cordic
        ebc_cordic_cell #(.STAGE(g)) u_cell (
            .clk(clk), .en(adv),
            .x_in(cx_w[g]), .y_in(cy_w[g]), .z_in(cz_w[g]),
            .x_out(cx_w[g+1]), .y_out(cy_w[g+1]), .z_out(cz_w[g+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
                side_reg[g+1] <= side_reg[g];
        end
    end

    // ---------------- stage M1: sign fix, axis squares ----------------
    logic signed [CW-1:0] c_reg, s_reg;
    logic [A2-1:0] a2_reg, b2_reg;
    logic [CENTER_W-1:0] m1cx_reg, m1cy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c_reg <= side_reg[NS].flip ? -cx_w[NS] : cx_w[NS];
            s_reg <= side_reg[NS].flip ? -cy_w[NS] : cy_w[NS];
            a2_reg <= side_reg[NS].a * side_reg[NS].a;
            b2_reg <= side_reg[NS].b * side_reg[NS].b;
            m1cx_reg <= side_reg[NS].cx;
            m1cy_reg <= side_reg[NS].cy;
        end
    end

    // ---------------- stage M2: c^2, s^2, c*s in Q30 ----------------
    localparam int PW = 2 * CW;
    logic signed [PW-1:0] cc, ss, csp;
    logic [31:0] c2_next, s2_next;
    logic signed [32:0] cs_next;
    always_comb
    begin
        cc  = c_reg * c_reg + (PW'(1) <<< 29);
        ss  = s_reg * s_reg + (PW'(1) <<< 29);
        csp = c_reg * s_reg + (PW'(1) <<< 29);
        c2_next = 32'(cc >>> 30);
        s2_next = 32'(ss >>> 30);
        cs_next = 33'(csp >>> 30);
    end
    logic [31:0] c2_reg, s2_reg;
    logic signed [32:0] cs_reg;
    logic [A2-1:0] a2b_reg, b2b_reg;
    logic signed [A2:0] d_reg;
    logic [CENTER_W-1:0] m2cx_reg, m2cy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c2_reg <= c2_next;
            s2_reg <= s2_next;
            cs_reg <= cs_next;
            a2b_reg <= a2_reg;
            b2b_reg <= b2_reg;
            d_reg <= $signed({1'b0, a2_reg}) - $signed({1'b0, b2_reg});
            m2cx_reg <= m1cx_reg;
            m2cy_reg <= m1cy_reg;
        end
    end

    // ---------------- stage M3: products ----------------
    localparam int QW = A2 + 32;
    logic [QW-1:0] pac_reg, pbs_reg, pas_reg, pbc_reg;
    logic signed [QW+1:0] pxy_reg;
    logic [CENTER_W-1:0] m3cx_reg, m3cy_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            pac_reg <= QW'(a2b_reg) * QW'(c2_reg);
            pbs_reg <= QW'(b2b_reg) * QW'(s2_reg);
            pas_reg <= QW'(a2b_reg) * QW'(s2_reg);
            pbc_reg <= QW'(b2b_reg) * QW'(c2_reg);
            pxy_reg <= (QW+2)'(d_reg) * (QW+2)'(cs_reg);
            m3cx_reg <= m2cx_reg;
            m3cy_reg <= m2cy_reg;
        end
    end

    // ---------------- stage M4: round, saturate ----------------
    logic [QW:0] sxx, syy;
    logic signed [QW+1:0] sxy;
    logic [QW:0] xx_full, yy_full;
    logic signed [QW+1:0] xy_full;
    logic [COV_W-1:0] xx_next, yy_next, xy_next;
    always_comb
    begin
        sxx = (QW+1)'(pac_reg) + (QW+1)'(pbs_reg) + ((QW+1)'(1) << 29);
        syy = (QW+1)'(pas_reg) + (QW+1)'(pbc_reg) + ((QW+1)'(1) << 29);
        sxy = pxy_reg + ((QW+2)'(1) <<< 29);
        xx_full = sxx >> 30;
        yy_full = syy >> 30;
        xy_full = sxy >>> 30;
        xx_next = (xx_full > (QW+1)'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : xx_full[31:0];
        yy_next = (yy_full > (QW+1)'(32'hFFFFFFFF)) ? 32'hFFFFFFFF : yy_full[31:0];
        if (xy_full > (QW+2)'(32'sh7FFFFFFF))
            xy_next = 32'h7FFFFFFF;
        else if (xy_full < -((QW+2)'(1) <<< 31))
            xy_next = 32'h80000000;
        else
            xy_next = xy_full[31:0];
    end

    typedef struct packed {
        logic [CENTER_W-1:0] cx;
        logic [CENTER_W-1:0] cy;
        logic [COV_W-1:0] xx;
        logic [COV_W-1:0] xy;
        logic [COV_W-1:0] yy;
    } res_t;

    res_t res_reg [0:SQRT_STEPS];
    always_ff @(posedge clk)
    begin
        if (adv)
            res_reg[0] <= '{cx: m3cx_reg, cy: m3cy_reg, xx: xx_next, xy: xy_next,
                            yy: yy_next};
    end

    // ---------------- square-root chains on 4*xx and 4*yy ----------------
    logic [SQRT_IN_W-1:0] wr_w [0:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] wq_w [0:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] hr_w [0:SQRT_STEPS];
    logic [SQRT_IN_W-1:0] hq_w [0:SQRT_STEPS];
    assign wr_w[0] = {res_reg[0].xx, 2'b00};
    assign hr_w[0] = {res_reg[0].yy, 2'b00};
    assign wq_w[0] = '0;
    assign hq_w[0] = '0;

    for (genvar k = 0; k < SQRT_STEPS; k++)
    begin : g_sqrt
        ebc_sqrt_cell #(.STEP(SQRT_STEPS-1-k)) u_w (
            .clk(clk), .en(adv), .rem_in(wr_w[k]), .root_in(wq_w[k]),
            .rem_out(wr_w[k+1]), .root_out(wq_w[k+1])
        );
        ebc_sqrt_cell #(.STEP(SQRT_STEPS-1-k)) u_h (
            .clk(clk), .en(adv), .rem_in(hr_w[k]), .root_in(hq_w[k]),
            .rem_out(hr_w[k+1]), .root_out(hq_w[k+1])
        );
        always_ff @(posedge clk)
        begin
            if (adv)
                res_reg[k+1] <= res_reg[k];
        end
    end

    // round to nearest: bump when remainder exceeds root; saturate
    logic [SQRT_IN_W-1:0] w_r, h_r;
    logic [SIZE_W-1:0] width_o, height_o;
    always_comb
    begin
        w_r = wq_w[SQRT_STEPS] + SQRT_IN_W'(wr_w[SQRT_STEPS] > wq_w[SQRT_STEPS]);
        h_r = hq_w[SQRT_STEPS] + SQRT_IN_W'(hr_w[SQRT_STEPS] > hq_w[SQRT_STEPS]);
        width_o  = (w_r > SQRT_IN_W'(131071)) ? 17'h1FFFF : w_r[SIZE_W-1:0];
        height_o = (h_r > SQRT_IN_W'(131071)) ? 17'h1FFFF : h_r[SIZE_W-1:0];
    end

    assign m_axis_tdata = {6'b000000, res_reg[SQRT_STEPS].yy, res_reg[SQRT_STEPS].xy,
                           res_reg[SQRT_STEPS].xx, height_o, width_o,
                           res_reg[SQRT_STEPS].cy, res_reg[SQRT_STEPS].cx};

`ifndef ASSERT_OFF
    // a stalled output never loses its beat
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output beat dropped under stall");
    // input accepted only when the chain advances
    a_ready: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready == (!m_axis_tvalid || m_axis_tready))
        else $error("ready does not follow pipeline advance");
    // covariance diagonal saturation implies saturated box size
    a_sat: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && res_reg[SQRT_STEPS].xx == 32'hFFFFFFFF |->
        width_o == 17'h1FFFF)
        else $error("box width not saturated");
`endif
endmodule

// ----- hdl/ebc_cordic_cell.sv -----
// ============================================================================
// ebc_cordic_cell: one CORDIC rotation stage
// Shifts by its stage number, steers on the residual angle sign, registers.
// ============================================================================
module ebc_cordic_cell
    import ebc_pkg::*;
#(
    parameter int STAGE = 0
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic signed [CW-1:0] x_in,
    input  logic signed [CW-1:0] y_in,
    input  logic signed [ZW-1:0] z_in,
    output logic signed [CW-1:0] x_out,
    output logic signed [CW-1:0] y_out,
    output logic signed [ZW-1:0] z_out
);
    logic signed [CW-1:0] dx, dy, x_next, y_next;
    logic signed [ZW-1:0] z_next;
    logic signed [CW-1:0] x_reg, y_reg;
    logic signed [ZW-1:0] z_reg;

    always_comb
    begin
        dx = y_in >>> STAGE;
        dy = x_in >>> STAGE;
        if (!z_in[ZW-1])
        begin
            x_next = x_in - dx;
            y_next = y_in + dy;
            z_next = z_in - atan_turn(STAGE);
        end
        else
        begin
            x_next = x_in + dx;
            y_next = y_in - dy;
            z_next = z_in + atan_turn(STAGE);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            x_reg <= x_next;
            y_reg <= y_next;
            z_reg <= z_next;
        end
    end

    assign x_out = x_reg;
    assign y_out = y_reg;
    assign z_out = z_reg;
endmodule

// ----- hdl/ebc_sqrt_cell.sv -----
// ============================================================================
// ebc_sqrt_cell: one restoring square-root step
// Resolves one result bit and hands remainder and partial root onward.
// ============================================================================
module ebc_sqrt_cell
    import ebc_pkg::*;
#(
    parameter int STEP = 0      // bit weight 4^STEP of this cell
) (
    input  logic                 clk,
    input  logic                 en,
    input  logic [SQRT_IN_W-1:0] rem_in,
    input  logic [SQRT_IN_W-1:0] root_in,
    output logic [SQRT_IN_W-1:0] rem_out,
    output logic [SQRT_IN_W-1:0] root_out
);
    logic [SQRT_IN_W-1:0] bitv, trial, rem_next, root_next, rem_reg, root_reg;

    always_comb
    begin
        bitv  = SQRT_IN_W'(1) << (2 * STEP);
        trial = root_in + bitv;
        if (rem_in >= trial)
        begin
            rem_next  = rem_in - trial;
            root_next = (root_in >> 1) + bitv;
        end
        else
        begin
            rem_next  = rem_in;
            root_next = root_in >> 1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg  <= rem_next;
            root_reg <= root_next;
        end
    end

    assign rem_out  = rem_reg;
    assign root_out = root_reg;
endmodule
